@@ hdl/sensor_timestamp_interval_matcher_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sensor timestamp interval matcher
// Shared property forms; each macro expects clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef SENSOR_TIMESTAMP_INTERVAL_MATCHER_TOP_ASSERT_SVH
`define SENSOR_TIMESTAMP_INTERVAL_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define STIM_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("stim assertion failed: same-cycle check");

// next-cycle implication
`define STIM_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("stim assertion failed: next-cycle check");

`endif

@@ hdl/stim_pkg.sv @@
// ----------------------------------------------------------------------------
// stim_pkg
// Types and constants shared by the timestamp interval matcher modules.
// ----------------------------------------------------------------------------
package stim_pkg;

   // request kinds, carried in req_tuser
   typedef enum logic [1:0] {
      KIND_FOOT     = 2'd0,
      KIND_ATTITUDE = 2'd1,
      KIND_SPEED    = 2'd2,
      KIND_IMU      = 2'd3
   } kind_type;

   // result status, carried in rsp_tuser
   typedef enum logic [2:0] {
      ST_STORED = 3'd0,
      ST_FEW    = 3'd1,
      ST_OLD    = 3'd2,
      ST_MATCH  = 3'd3,
      ST_NEWER  = 3'd4
   } status_type;

   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int SLOT_W      = 8;
   localparam int COUNT_W     = 4;
   localparam int FILL_W      = 9;
   localparam int RSP_TDATA_W = 24;

   // head of the command queue as seen by the engine
   typedef struct packed {
      logic     valid;
      logic     is_foot;
      kind_type kind;
   } queue_head_type;

   // one result item
   typedef struct packed {
      status_type          status;
      logic                pop;
      logic [SLOT_W-1:0]   slot;
      logic [COUNT_W-1:0]  count;
      logic [FILL_W-1:0]   fill;
   } result_type;

endpackage

@@ hdl/stim_ram.sv @@
// ----------------------------------------------------------------------------
// stim_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/stim_front.sv @@
// ----------------------------------------------------------------------------
// stim_front
// Input side: takes request transfers, tags feet and messages, and holds
// them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module stim_front
   import stim_pkg::*;
#(
   parameter int TIME_WIDTH = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [TIME_WIDTH-1:0] req_time,
   output queue_head_type        q_head,
   output logic [TIME_WIDTH-1:0] q_time,
   input  logic                  q_pop
);

   logic                  ent_foot_ff [2];
   kind_type              ent_kind_ff [2];
   logic [TIME_WIDTH-1:0] ent_time_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   logic                  pop;
   kind_type              in_kind;

   assign in_kind    = kind_type'(req_kind);
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (count_ff != 2'd0);

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, classified on entry
   always_ff @(posedge clock) begin
      if (push) begin
         ent_foot_ff[wr_ptr_ff] <= (in_kind == KIND_FOOT);
         ent_kind_ff[wr_ptr_ff] <= in_kind;
         ent_time_ff[wr_ptr_ff] <= req_time;
      end
   end

   assign q_head.valid   = (count_ff != 2'd0);
   assign q_head.is_foot = ent_foot_ff[rd_ptr_ff];
   assign q_head.kind    = ent_kind_ff[rd_ptr_ff];
   assign q_time         = ent_time_ff[rd_ptr_ff];

endmodule

@@ hdl/stim_engine.sv @@
// ----------------------------------------------------------------------------
// stim_engine
// Back end: keeps the foot table as a ring in RAM (newest at the head),
// searches it for each message and updates the per-slot counts and flags.
// ----------------------------------------------------------------------------
module stim_engine
   import stim_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int SUB_DEPTH   = 16,
   parameter int TIME_WIDTH  = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        q_head,
   input  logic [TIME_WIDTH-1:0] q_time,
   output logic                  q_pop,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output result_type            rsp_data
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int FW   = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = $clog2(SUB_DEPTH);
   localparam int CNTW = 3 * CW;
   localparam int SXW  = (AW > SLOT_W)  ? AW : SLOT_W;
   localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int FXW  = (FW > FILL_W)  ? FW : FILL_W;

   localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(TABLE_DEPTH);
   localparam logic [CW-1:0] COUNT_MAX = CW'(SUB_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OLDEST,
      S_NEWEST,
      S_BIN,
      S_LIN,
      S_FETCH,
      S_UPDATE,
      S_DONE
   } state_type;

   // logical slot to RAM address
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [AW-1:0] idx);
      logic [AW:0] s;
      s = {1'b0, base} + {1'b0, idx};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic                  sorted_ff, sorted_in;
   logic [TIME_WIDTH-1:0] newest_ff, newest_in;
   kind_type              kind_ff, kind_in;
   logic [TIME_WIDTH-1:0] t_ff, t_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic [TIME_WIDTH-1:0] prev_ff, prev_in;
   logic [AW-1:0]         idx_ff, idx_in;
   status_type            status_res_ff, status_res_in;
   logic [CW-1:0]         count_res_ff, count_res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                  time_wr_en, time_rd_en;
   logic [AW-1:0]         time_wr_addr, time_rd_addr;
   logic [TIME_WIDTH-1:0] time_wr_data, time_rd_data;
   logic                  cnt_wr_en, cnt_rd_en;
   logic [AW-1:0]         cnt_wr_addr, cnt_rd_addr;
   logic [CNTW-1:0]       cnt_wr_data, cnt_rd_data;
   logic                  flag_wr_en, flag_rd_en;
   logic [AW-1:0]         flag_wr_addr, flag_rd_addr;
   logic [2:0]            flag_wr_data, flag_rd_data;

   // helpers
   logic [AW-1:0]         head_new;
   logic [AW-1:0]         fill_last;
   logic [AW-1:0]         nlo, nhi;
   logic [AW:0]           nsum;
   logic [AW:0]           first_sum;
   logic [CW-1:0]         old_cnt, new_cnt;
   logic [2:0]            flag_bit;
   logic [SXW-1:0]        slot_wide;
   logic [CXW-1:0]        cnt_wide;
   logic [FXW-1:0]        fill_wide;
   logic                  out_free;

   assign head_new  = (head_ff == '0) ? LAST_IDX : head_ff - AW'(1);
   assign fill_last = fill_ff[AW-1:0] - AW'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // one binary search step: keep the half that holds the newest slot older than t
   always_comb begin
      if (time_rd_data < t_ff) begin
         nlo = lo_ff;
         nhi = cur_ff;
      end else begin
         nlo = cur_ff + AW'(1);
         nhi = hi_ff;
      end
      nsum      = {1'b0, nlo} + {1'b0, nhi};
      first_sum = {1'b0, fill_last} + (AW + 1)'(1);
   end

   // count field of this message kind, saturating increment
   always_comb begin
      unique case (kind_ff)
         KIND_ATTITUDE: begin
            old_cnt  = cnt_rd_data[CW-1:0];
            flag_bit = 3'b001;
         end
         KIND_SPEED: begin
            old_cnt  = cnt_rd_data[2*CW-1:CW];
            flag_bit = 3'b010;
         end
         KIND_IMU: begin
            old_cnt  = cnt_rd_data[3*CW-1:2*CW];
            flag_bit = 3'b100;
         end
         KIND_FOOT: begin
            old_cnt  = '0;
            flag_bit = 3'b000;
         end
      endcase
      new_cnt = (old_cnt < COUNT_MAX) ? old_cnt + CW'(1) : old_cnt;
   end

   assign slot_wide = SXW'(idx_ff);
   assign cnt_wide  = CXW'(count_res_ff);
   assign fill_wide = FXW'(fill_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      sorted_in     = sorted_ff;
      newest_in     = newest_ff;
      kind_in       = kind_ff;
      t_in          = t_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      idx_in        = idx_ff;
      status_res_in = status_res_ff;
      count_res_in  = count_res_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;

      time_wr_en    = 1'b0;
      time_wr_addr  = head_new;
      time_wr_data  = q_time;
      time_rd_en    = 1'b0;
      time_rd_addr  = '0;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = head_new;
      cnt_wr_data   = '0;
      cnt_rd_en     = 1'b0;
      cnt_rd_addr   = phys(head_ff, idx_ff);
      flag_wr_en    = 1'b0;
      flag_wr_addr  = head_new;
      flag_wr_data  = '0;
      flag_rd_en    = 1'b0;
      flag_rd_addr  = phys(head_ff, idx_ff + AW'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (q_head.valid) begin
               q_pop         = 1'b1;
               kind_in       = q_head.kind;
               t_in          = q_time;
               idx_in        = '0;
               count_res_in  = '0;
               if (q_head.is_foot) begin
                  // new foot goes in front of the head; a full ring drops its oldest
                  time_wr_en    = 1'b1;
                  cnt_wr_en     = 1'b1;
                  flag_wr_en    = 1'b1;
                  head_in       = head_new;
                  newest_in     = q_time;
                  sorted_in     = sorted_ff && ((fill_ff == '0) || (q_time >= newest_ff));
                  fill_in       = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + FW'(1);
                  status_res_in = ST_STORED;
                  state_in      = S_DONE;
               end else if (fill_ff < FW'(2)) begin
                  status_res_in = ST_FEW;
                  state_in      = S_DONE;
               end else begin
                  time_rd_en   = 1'b1;
                  time_rd_addr = phys(head_ff, fill_last);
                  state_in     = S_OLDEST;
               end
            end
         end

         S_OLDEST: begin
            if (time_rd_data >= t_ff) begin
               status_res_in = ST_OLD;
               state_in      = S_DONE;
            end else begin
               time_rd_en   = 1'b1;
               time_rd_addr = head_ff;
               state_in     = S_NEWEST;
            end
         end

         S_NEWEST: begin
            if (!sorted_ff) begin
               // unordered table: walk it from slot 1
               prev_in      = time_rd_data;
               cur_in       = AW'(1);
               time_rd_en   = 1'b1;
               time_rd_addr = phys(head_ff, AW'(1));
               state_in     = S_LIN;
            end else if (t_ff > time_rd_data) begin
               status_res_in = ST_NEWER;
               state_in      = S_DONE;
            end else begin
               lo_in = AW'(1);
               hi_in = fill_last;
               if (fill_last == AW'(1)) begin
                  idx_in   = AW'(1);
                  state_in = S_FETCH;
               end else begin
                  cur_in       = first_sum[AW:1];
                  time_rd_en   = 1'b1;
                  time_rd_addr = phys(head_ff, first_sum[AW:1]);
                  state_in     = S_BIN;
               end
            end
         end

         S_BIN: begin
            lo_in = nlo;
            hi_in = nhi;
            if (nlo == nhi) begin
               idx_in   = nlo;
               state_in = S_FETCH;
            end else begin
               cur_in       = nsum[AW:1];
               time_rd_en   = 1'b1;
               time_rd_addr = phys(head_ff, nsum[AW:1]);
            end
         end

         S_LIN: begin
            if ((t_ff > time_rd_data) && (t_ff <= prev_ff)) begin
               idx_in   = cur_ff;
               state_in = S_FETCH;
            end else if (cur_ff == fill_last) begin
               status_res_in = ST_NEWER;
               state_in      = S_DONE;
            end else begin
               prev_in      = time_rd_data;
               cur_in       = cur_ff + AW'(1);
               time_rd_en   = 1'b1;
               time_rd_addr = phys(head_ff, cur_ff + AW'(1));
            end
         end

         S_FETCH: begin
            cnt_rd_en  = 1'b1;
            flag_rd_en = 1'b1;
            state_in   = S_UPDATE;
         end

         S_UPDATE: begin
            // count on the matched slot, complete flag on the next older slot
            cnt_wr_en    = 1'b1;
            cnt_wr_addr  = phys(head_ff, idx_ff);
            cnt_wr_data  = cnt_rd_data;
            unique case (kind_ff)
               KIND_ATTITUDE: cnt_wr_data[CW-1:0]      = new_cnt;
               KIND_SPEED:    cnt_wr_data[2*CW-1:CW]   = new_cnt;
               KIND_IMU:      cnt_wr_data[3*CW-1:2*CW] = new_cnt;
               KIND_FOOT:     cnt_wr_data              = cnt_rd_data;
            endcase
            flag_wr_en    = (idx_ff != LAST_IDX);
            flag_wr_addr  = phys(head_ff, idx_ff + AW'(1));
            flag_wr_data  = flag_rd_data | flag_bit;
            count_res_in  = new_cnt;
            status_res_in = ST_MATCH;
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_res_ff;
               rsp_data_in.pop    = (status_res_ff == ST_OLD) || (status_res_ff == ST_MATCH);
               rsp_data_in.slot   = slot_wide[SLOT_W-1:0];
               rsp_data_in.count  = cnt_wide[COUNT_W-1:0];
               rsp_data_in.fill   = fill_wide[FILL_W-1:0];
               state_in           = S_IDLE;
            end
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         sorted_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newest_ff     <= newest_in;
      kind_ff       <= kind_in;
      t_ff          <= t_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      idx_ff        <= idx_in;
      status_res_ff <= status_res_in;
      count_res_ff  <= count_res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // foot times
   stim_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (time_wr_en),
      .wr_addr (time_wr_addr),
      .wr_data (time_wr_data),
      .rd_en   (time_rd_en),
      .rd_addr (time_rd_addr),
      .rd_data (time_rd_data)
   );

   // attitude, speed and IMU counts, lowest field first
   stim_ram #(
      .WIDTH (CNTW),
      .DEPTH (TABLE_DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // complete flags: bit0 attitude, bit1 speed, bit2 IMU
   stim_ram #(
      .WIDTH (3),
      .DEPTH (TABLE_DEPTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_wr_en),
      .wr_addr (flag_wr_addr),
      .wr_data (flag_wr_data),
      .rd_en   (flag_rd_en),
      .rd_addr (flag_rd_addr),
      .rd_data (flag_rd_data)
   );

endmodule

@@ hdl/sensor_timestamp_interval_matcher_top.sv @@
// ----------------------------------------------------------------------------
// sensor_timestamp_interval_matcher_top
// Matches sensor message timestamps against a newest-first table of feet.
//
//   channel   direction  ports                        fields
//   req       in         req_tvalid/tready/tuser/tdata  kind, timestamp
//   rsp       out        rsp_tvalid/tready/tuser/tdata  status, pop, slot, count, fill
//
// A new foot goes from queue head through S_IDLE and S_DONE to the result register.
// A message is located by binary search on a time-ordered table (one foot-time
// RAM read per step); once a foot arrives out of order the table is walked one
// slot per cycle.
// Reset is synchronous; no clearing pass, the fill count guards the table.
// A two-entry queue keeps req accepting, until it is full, while the engine works
// or a result waits on rsp_tready.
// ----------------------------------------------------------------------------
module sensor_timestamp_interval_matcher_top
   import stim_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int SUB_DEPTH   = 16,
   parameter int TIME_WIDTH  = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [KIND_W-1:0]                   req_tuser,   // [1:0] req_type
   input  logic [((TIME_WIDTH + 7) / 8)*8-1:0] req_tdata,   // timestamp
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [STATUS_W-1:0]                 rsp_tuser,   // [2:0] status
   output logic [RSP_TDATA_W-1:0]              rsp_tdata    // pop_message, slot_index,
                                                            // kind_count, fill_level
);

   queue_head_type        q_head;
   logic [TIME_WIDTH-1:0] q_time;
   logic                  q_pop;
   result_type            rsp_data;

   // front: request intake and queue
   stim_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_time   (req_tdata[TIME_WIDTH-1:0]),
      .q_head     (q_head),
      .q_time     (q_time),
      .q_pop      (q_pop)
   );

   // back: table search and update
   stim_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SUB_DEPTH   (SUB_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_time     (q_time),
      .q_pop      (q_pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data)
   );

   // result packing
   assign rsp_tuser = rsp_data.status;
   assign rsp_tdata = {2'b00, rsp_data.fill, rsp_data.count, rsp_data.slot, rsp_data.pop};

endmodule

@@ hdl/stim_checker.sv @@
// ----------------------------------------------------------------------------
// stim_checker
// Port-level checks on result transfers of the interval matcher.
// ----------------------------------------------------------------------------
`include "sensor_timestamp_interval_matcher_top_assert.svh"

module stim_checker
   import stim_pkg::*;
(
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [STATUS_W-1:0]                 rsp_tuser,   // [2:0] status
   input logic [RSP_TDATA_W-1:0]              rsp_tdata    // pop, slot, count, fill
);

   logic rsp_is_match;
   logic rsp_pops;

   assign rsp_is_match = (rsp_tuser == ST_MATCH);
   assign rsp_pops     = (rsp_tuser == ST_OLD) || (rsp_tuser == ST_MATCH);

   // a stalled result holds
   `STIM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // pop flag follows the status
   `STIM_ASSERT_NOW(a_pop_status, rsp_tvalid, rsp_tdata[0] == rsp_pops)

   // slot and count are zero unless matched
   `STIM_ASSERT_NOW(a_nomatch_zero, rsp_tvalid && !rsp_is_match, rsp_tdata[12:1] == 12'd0)

   // too-few status only with fewer than two feet held
   `STIM_ASSERT_NOW(a_few_fill, rsp_tvalid && (rsp_tuser == ST_FEW), rsp_tdata[21:13] < 9'd2)

   // a stored foot always leaves at least one foot held
   `STIM_ASSERT_NOW(a_stored_fill, rsp_tvalid && (rsp_tuser == ST_STORED), rsp_tdata[21:13] != 9'd0)

endmodule

bind sensor_timestamp_interval_matcher_top stim_checker u_stim_checker (.*);
